### src/uto_pkg.sv
// Shared types and constants for the tick-oversampled 8N1 UART core.
package uto_pkg;

	localparam int FIFO_DEPTH_DEF = 16;

	// Command queue between the front and back parts.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [0:0] REG_RX_ENABLE = 1'b0;

	// Frame timing and layout.
	localparam logic [3:0] FRAME_BITS = 4'd10;
	localparam logic [3:0] DATA_BITS = 4'd8;
	localparam logic [1:0] TX_BIT_TICKS = 2'd3;
	localparam logic [2:0] RX_BIT_TICKS = 3'd3;
	localparam logic [2:0] FIRST_SAMPLE_TICKS = 3'd4;
	localparam logic [9:0] STOP_MARK = 10'h200;
	localparam logic [7:0] FIRST_BIT_MASK = 8'h01;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_PUT   = 2'd1,
		FUNC_GET   = 2'd2,
		FUNC_FLUSH = 2'd3
	} func_t;

	typedef struct packed {
		func_t      op;
		logic       rx_line;
		logic [7:0] tx_byte;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

### src/uto_front.sv
// Input side: accepts transactions, decodes the function code and queues commands.
module uto_front import uto_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic       rx_line,
	input  logic [7:0] tx_byte,
	output q_head_t    q_head,
	input  logic       q_pop
);

	localparam logic [Q_PTR_W-1:0] Q_LAST = Q_PTR_W'(Q_DEPTH - 1);
	localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

	cmd_t               q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push;
	cmd_t               cmd_in;

	assign in_stall = (cnt_q == Q_FULL);
	assign push     = in_valid && !in_stall;

	always_comb begin
		cmd_in.op      = func_t'(func);
		cmd_in.rx_line = rx_line;
		cmd_in.tx_byte = tx_byte;
	end

	assign q_head.valid = (cnt_q != '0);
	assign q_head.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("command queue popped while empty");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_FULL)
		else $error("command queue count beyond its depth");

endmodule

### src/uto_back.sv
// Execution side: transmitter, receiver, receive FIFO and the result register.
module uto_back import uto_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_enable,
	input  q_head_t    q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_line,
	output logic       tx_busy,
	output logic       put_accepted,
	output logic       rx_available,
	output logic [7:0] read_byte,
	output logic       read_valid
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]       fifo_mem [FIFO_DEPTH];

	logic             tx_level_q, tx_level_d;
	logic             tx_active_q, tx_active_d;
	logic [1:0]       tx_cnt_q, tx_cnt_d;
	logic [3:0]       tx_bits_q, tx_bits_d;
	logic [9:0]       tx_shift_q, tx_shift_d;
	logic             rx_in_frame_q, rx_in_frame_d;
	logic             rx_wait_stop_q, rx_wait_stop_d;
	logic [2:0]       rx_cnt_q, rx_cnt_d;
	logic [3:0]       rx_bits_q, rx_bits_d;
	logic [7:0]       rx_mask_q, rx_mask_d;
	logic [7:0]       rx_shift_q, rx_shift_d;
	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;

	logic             out_valid_q;
	logic             tx_line_q, tx_busy_q, put_acc_q, rx_avail_q, read_valid_q;
	logic [7:0]       read_byte_q;

	logic             exec;
	logic             accepted;
	logic             fifo_we;
	logic             fifo_re;

	// The result register takes a new result when it is empty or being drained.
	assign exec  = q_head.valid && (!out_valid_q || !out_stall);
	assign q_pop = exec;

	always_comb begin
		tx_level_d     = tx_level_q;
		tx_active_d    = tx_active_q;
		tx_cnt_d       = tx_cnt_q;
		tx_bits_d      = tx_bits_q;
		tx_shift_d     = tx_shift_q;
		rx_in_frame_d  = rx_in_frame_q;
		rx_wait_stop_d = rx_wait_stop_q;
		rx_cnt_d       = rx_cnt_q;
		rx_bits_d      = rx_bits_q;
		rx_mask_d      = rx_mask_q;
		rx_shift_d     = rx_shift_q;
		wr_ptr_d       = wr_ptr_q;
		rd_ptr_d       = rd_ptr_q;
		accepted       = 1'b0;
		fifo_we        = 1'b0;
		fifo_re        = 1'b0;
		unique case (q_head.cmd.op)
			FUNC_TICK: begin
				if (tx_active_q) begin
					tx_cnt_d = tx_cnt_q - 2'd1;
					if (tx_cnt_d == '0) begin
						tx_level_d = tx_shift_q[0];
						tx_shift_d = {1'b0, tx_shift_q[9:1]};
						tx_cnt_d   = TX_BIT_TICKS;
						tx_bits_d  = tx_bits_q - 4'd1;
						if (tx_bits_d == '0) begin
							tx_active_d = 1'b0;
						end
					end
				end
				if (rx_enable) begin
					if (rx_wait_stop_q) begin
						rx_cnt_d = rx_cnt_q - 3'd1;
						if (rx_cnt_d == '0) begin
							rx_wait_stop_d = 1'b0;
							rx_in_frame_d  = 1'b0;
							fifo_we        = 1'b1;
							wr_ptr_d       = ptr_next(wr_ptr_q);
						end
					end else if (!rx_in_frame_q) begin
						if (!q_head.cmd.rx_line) begin
							rx_in_frame_d = 1'b1;
							rx_shift_d    = '0;
							rx_cnt_d      = FIRST_SAMPLE_TICKS;
							rx_bits_d     = DATA_BITS;
							rx_mask_d     = FIRST_BIT_MASK;
						end
					end else begin
						rx_cnt_d = rx_cnt_q - 3'd1;
						if (rx_cnt_d == '0) begin
							rx_cnt_d = RX_BIT_TICKS;
							if (q_head.cmd.rx_line) begin
								rx_shift_d = rx_shift_q | rx_mask_q;
							end
							rx_mask_d = {rx_mask_q[6:0], 1'b0};
							rx_bits_d = rx_bits_q - 4'd1;
							if (rx_bits_d == '0) begin
								rx_wait_stop_d = 1'b1;
							end
						end
					end
				end
			end
			FUNC_PUT: begin
				if (!tx_active_q) begin
					tx_cnt_d    = TX_BIT_TICKS;
					tx_bits_d   = FRAME_BITS;
					tx_shift_d  = {1'b0, q_head.cmd.tx_byte, 1'b0} | STOP_MARK;
					tx_active_d = 1'b1;
					accepted    = 1'b1;
				end
			end
			FUNC_GET: begin
				if (wr_ptr_q != rd_ptr_q) begin
					fifo_re  = 1'b1;
					rd_ptr_d = ptr_next(rd_ptr_q);
				end
			end
			FUNC_FLUSH: begin
				wr_ptr_d = '0;
				rd_ptr_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_level_q     <= 1'b1;
			tx_active_q    <= 1'b0;
			tx_cnt_q       <= '0;
			tx_bits_q      <= '0;
			tx_shift_q     <= '0;
			rx_in_frame_q  <= 1'b0;
			rx_wait_stop_q <= 1'b0;
			rx_cnt_q       <= '0;
			rx_bits_q      <= '0;
			rx_mask_q      <= '0;
			rx_shift_q     <= '0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (exec) begin
				tx_level_q     <= tx_level_d;
				tx_active_q    <= tx_active_d;
				tx_cnt_q       <= tx_cnt_d;
				tx_bits_q      <= tx_bits_d;
				tx_shift_q     <= tx_shift_d;
				rx_in_frame_q  <= rx_in_frame_d;
				rx_wait_stop_q <= rx_wait_stop_d;
				rx_cnt_q       <= rx_cnt_d;
				rx_bits_q      <= rx_bits_d;
				rx_mask_q      <= rx_mask_d;
				rx_shift_q     <= rx_shift_d;
				wr_ptr_q       <= wr_ptr_d;
				rd_ptr_q       <= rd_ptr_d;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A tick and a read never share a cycle, so the ports never collide.
	always_ff @(posedge clk) begin
		if (exec && fifo_we) begin
			fifo_mem[wr_ptr_q] <= rx_shift_q;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_byte_q <= fifo_re ? fifo_mem[rd_ptr_q] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			tx_line_q    <= tx_level_d;
			tx_busy_q    <= tx_active_d;
			put_acc_q    <= accepted;
			rx_avail_q   <= (wr_ptr_d != rd_ptr_d);
			read_valid_q <= fifo_re;
		end
	end

	assign out_valid    = out_valid_q;
	assign tx_line      = tx_line_q;
	assign tx_busy      = tx_busy_q;
	assign put_accepted = put_acc_q;
	assign rx_available = rx_avail_q;
	assign read_byte    = read_byte_q;
	assign read_valid   = read_valid_q;

	a_put_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && put_acc_q |-> tx_busy_q)
		else $error("accepted put without a busy transmitter");

	a_empty_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !read_valid_q |-> read_byte_q == '0)
		else $error("read byte nonzero on a failed get");

	a_tx_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_active_q |-> tx_level_q)
		else $error("transmit line low while transmitter idle");

	a_stop_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rx_wait_stop_q |-> rx_in_frame_q)
		else $error("receiver waits for stop outside a frame");

endmodule

### src/uart_8n1_tick_oversampled_core.sv
// Top level of the 8N1 UART core driven by ticks at three times the baud rate.
//
// Input channel (in_valid / in_stall): one transaction carries func, rx_line and
// tx_byte. A baud tick advances the transmitter and, while rx_enable is set, the
// receiver; put char starts a frame unless one is in progress; get char pops the
// receive FIFO; flush empties it.
// Output channel (out_valid / out_stall): exactly one result transaction per input
// transaction, in order, giving the line level, busy flag, put acceptance, FIFO
// status and the byte read.
// Accepted commands pass the queue, then the result register. Throughput is one
// transaction per cycle while out_stall is low; ticks alone set all frame timing.
// A two-entry command queue sits between decode and execution, and a result
// register holds the output. When the receiver stalls, results wait in that
// register, the queue fills, and in_stall rises once both queue entries are taken.
// Reset clears the queue and out_valid, idles the transmitter level high, sets
// rx_enable to 1 and empties the FIFO; FIFO contents are undefined until written.
// rx_enable is written through the APB port at byte address 0.
module uart_8n1_tick_oversampled_core import uto_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            func,
	input  logic                  rx_line,
	input  logic [7:0]            tx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  tx_line,
	output logic                  tx_busy,
	output logic                  put_accepted,
	output logic                  rx_available,
	output logic [7:0]            read_byte,
	output logic                  read_valid
);

	logic       rx_enable_q;
	logic [0:0] reg_idx;
	logic       cfg_write;
	q_head_t    q_head;
	logic       q_pop;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[2:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q <= 1'b1;
		end else if (cfg_write && (reg_idx == REG_RX_ENABLE)) begin
			rx_enable_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_RX_ENABLE) begin
			prdata[0] = rx_enable_q;
		end
	end

	uto_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.rx_line  (rx_line),
		.tx_byte  (tx_byte),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	uto_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_enable    (rx_enable_q),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tx_line      (tx_line),
		.tx_busy      (tx_busy),
		.put_accepted (put_accepted),
		.rx_available (rx_available),
		.read_byte    (read_byte),
		.read_valid   (read_valid)
	);

endmodule
